[hdl/rotation_matrix_to_quaternion_core_assert.svh]
// assertion macros shared by the rotation matrix to quaternion checker
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// checked at every clock edge outside of reset
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every clock edge, reset included
`define RMQ_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/rmq_pkg.sv]
// types, constants and width helpers for the rotation matrix to quaternion core
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int QUEUE_DEPTH    = 2;

  // the largest normalized magnitude sits in [2^29, 2^30)
  localparam int NORM_W = 30;
  localparam int SQ_W   = 2 * NORM_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int RND_W  = ROOT_W + 1;

  typedef enum logic [1:0] {
    BR_X,
    BR_Y,
    BR_Z,
    BR_W
  } branch_e;

  // signed width that holds one plus three matrix entries
  function automatic int vec_w(input int dw, input int fb);
    return ((dw > fb + 2) ? dw : fb + 2) + 2;
  endfunction

endpackage

[hdl/rmq_if.sv]
// stream interfaces for matrix input and quaternion output
`timescale 1ns / 1ps

interface rmq_in_if #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] m00;
  logic signed [DATA_WIDTH-1:0] m01;
  logic signed [DATA_WIDTH-1:0] m02;
  logic signed [DATA_WIDTH-1:0] m10;
  logic signed [DATA_WIDTH-1:0] m11;
  logic signed [DATA_WIDTH-1:0] m12;
  logic signed [DATA_WIDTH-1:0] m20;
  logic signed [DATA_WIDTH-1:0] m21;
  logic signed [DATA_WIDTH-1:0] m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

interface rmq_out_if #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] q_x;
  logic signed [DATA_WIDTH-1:0] q_y;
  logic signed [DATA_WIDTH-1:0] q_z;
  logic signed [DATA_WIDTH-1:0] q_w;
  logic                         bad_input;

  modport source (
    output valid, q_x, q_y, q_z, q_w, bad_input,
    input  ready
  );
  modport sink (
    input  valid, q_x, q_y, q_z, q_w, bad_input,
    output ready
  );
endinterface

[hdl/rmq_front.sv]
// front end: accepts a matrix, picks the branch and forms the unnormalized quaternion
`timescale 1ns / 1ps

module rmq_front #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  rmq_in_if.sink in_i,
  output logic   wr_valid_o,
  input  logic   wr_ready_i,
  output logic [5*rmq_pkg::vec_w(DATA_WIDTH, FRAC_BITS)+4:0] wr_data_o
);
  import rmq_pkg::*;

  localparam int VW = vec_w(DATA_WIDTH, FRAC_BITS);
  localparam logic signed [VW-1:0] One  = VW'(1) << FRAC_BITS;
  localparam logic signed [VW-1:0] Zero = '0;

  logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [VW-1:0] t, arg;
  logic signed [VW-1:0] v [4];
  logic [VW-1:0]        mag [4];
  logic [VW-1:0]        mx;
  logic [3:0]           neg;
  logic                 err;
  branch_e              br;

  assign e00 = VW'(in_i.m00);
  assign e01 = VW'(in_i.m01);
  assign e02 = VW'(in_i.m02);
  assign e10 = VW'(in_i.m10);
  assign e11 = VW'(in_i.m11);
  assign e12 = VW'(in_i.m12);
  assign e20 = VW'(in_i.m20);
  assign e21 = VW'(in_i.m21);
  assign e22 = VW'(in_i.m22);

  always_comb begin
    t  = One + e00 + e11 + e22;
    br = BR_W;
    if (t[VW-1] || t == Zero) begin
      br = BR_X;
      if (e11 > e00) begin
        br = BR_Y;
      end
      if (e22 > ((br == BR_Y) ? e11 : e00)) begin
        br = BR_Z;
      end
    end

    unique case (br)
      BR_W: begin
        arg  = t;
        v[0] = e21 - e12;
        v[1] = e02 - e20;
        v[2] = e10 - e01;
        v[3] = t;
      end
      BR_X: begin
        arg  = One + e00 - e11 - e22;
        v[0] = arg;
        v[1] = e01 + e10;
        v[2] = e02 + e20;
        v[3] = e21 - e12;
      end
      BR_Y: begin
        arg  = One + e11 - e00 - e22;
        v[0] = e01 + e10;
        v[1] = arg;
        v[2] = e12 + e21;
        v[3] = e02 - e20;
      end
      BR_Z: begin
        arg  = One + e22 - e00 - e11;
        v[0] = e02 + e20;
        v[1] = e12 + e21;
        v[2] = arg;
        v[3] = e10 - e01;
      end
    endcase

    mx = '0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i][VW-1];
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > mx) begin
        mx = mag[i];
      end
    end

    err = ((br != BR_W) && (arg[VW-1] || arg == Zero)) || (mx == '0);
  end

  assign wr_data_o  = {err, neg, mx, mag[3], mag[2], mag[1], mag[0]};
  assign wr_valid_o = in_i.valid;
  assign in_i.ready = wr_ready_i;

endmodule

[hdl/rmq_fifo.sv]
// short queue between front end and back end
`timescale 1ns / 1ps

module rmq_fifo #(
  parameter int Width = 8,
  parameter int Depth = rmq_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);
  localparam int PW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      cnt_q;
  logic             push, pop;

  assign wr_ready_o = cnt_q != (PW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[hdl/rmq_back.sv]
// back end: normalization pipeline with bit-serial root and divider stages
`timescale 1ns / 1ps

module rmq_back #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic rd_valid_i,
  output logic rd_ready_o,
  input  logic [5*rmq_pkg::vec_w(DATA_WIDTH, FRAC_BITS)+4:0] rd_data_i,
  rmq_out_if.source out_o
);
  import rmq_pkg::*;

  localparam int VW     = vec_w(DATA_WIDTH, FRAC_BITS);
  localparam int EW     = 5 * VW + 5;
  localparam int PosW   = $clog2(VW);
  localparam int WideW  = VW + NORM_W - 1;
  localparam int QW     = FRAC_BITS + 1;
  localparam int NW     = NORM_W + FRAC_BITS + 1;
  localparam int XW     = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
  localparam int SqrtS  = 5;
  localparam int RndS   = SqrtS + ROOT_W;
  localparam int PrepS  = RndS + 1;
  localparam int DivS   = PrepS + 1;
  localparam int OutS   = DivS + QW;
  localparam int NST    = OutS + 1;
  localparam logic [XW-1:0] MaxPos = XW'({(DATA_WIDTH-1){1'b1}});
  localparam logic [XW-1:0] MaxNeg = MaxPos + 1'b1;

  logic                  adv;
  logic                  vld_q [NST];
  logic                  err_q [OutS];
  logic [3:0]            neg_q [OutS];

  logic [VW-1:0]         mag_in [4];
  logic [VW-1:0]         mx_in;
  logic [PosW-1:0]       p_d, p_q;
  logic [VW-1:0]         mag0_q [4];
  logic [WideW-1:0]      wide [4];
  logic [NORM_W-1:0]     a1_d [4];
  logic [NORM_W-1:0]     a1_q [4];
  logic [NORM_W-1:0]     a2_q [4];
  logic [NORM_W-1:0]     a3_q [4];
  logic [NORM_W-1:0]     a4_q [4];
  logic [SQ_W-1:0]       sq2_q [4];
  logic [SQ_W:0]         ps3_q [2];
  logic [SUM_W-1:0]      s4_q;

  logic [REM_W-1:0]      rem_d [ROOT_W];
  logic [REM_W-1:0]      rem_q [ROOT_W];
  logic [ROOT_W-1:0]     root_d [ROOT_W];
  logic [ROOT_W-1:0]     root_q [ROOT_W];
  logic [SUM_W-1:0]      rad_d [ROOT_W];
  logic [SUM_W-1:0]      rad_q [ROOT_W];
  logic [NORM_W-1:0]     as_q [ROOT_W][4];

  logic [RND_W-1:0]      rr_d, rr_q;
  logic [NORM_W-1:0]     ar_q [4];
  logic [NW-1:0]         nv [4];
  logic [RND_W-1:0]      pp_q [4];
  logic [QW-1:0]         pl_q [4];
  logic [RND_W-1:0]      rp_q;

  logic [RND_W-1:0]      dp_d [QW][4];
  logic [RND_W-1:0]      dp_q [QW][4];
  logic [QW-1:0]         dl_d [QW][4];
  logic [QW-1:0]         dl_q [QW][4];
  logic [QW-1:0]         dq_d [QW][4];
  logic [QW-1:0]         dq_q [QW][4];
  logic [RND_W-1:0]      dr_q [QW];

  logic [XW-1:0]         mg [4];
  logic [XW-1:0]         lim [4];
  logic [XW-1:0]         ngv [4];
  logic [DATA_WIDTH-1:0] qo_d [4];
  logic [DATA_WIDTH-1:0] qo_q [4];
  logic                  bad_q;

  assign adv        = !vld_q[OutS] || out_o.ready;
  assign rd_ready_o = adv;

  // unpack queue entry and find the leading one of the largest magnitude
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_in[i] = rd_data_i[i*VW +: VW];
    end
    mx_in = rd_data_i[4*VW +: VW];
    p_d   = '0;
    for (int i = 0; i < VW; i++) begin
      if (mx_in[i]) begin
        p_d = PosW'(i);
      end
    end
  end

  // common shift puts the largest magnitude in [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide[i] = {mag0_q[i], {(NORM_W-1){1'b0}}} >> p_q;
      a1_d[i] = wide[i][NORM_W-1:0];
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in, rem2, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  rad_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = s4_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem2      = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
    assign trial     = REM_W'({root_in, 2'b01});
    assign ge        = rem2 >= trial;
    assign rem_d[k]  = ge ? rem2 - trial : rem2;
    assign root_d[k] = {root_in[ROOT_W-2:0], ge};
    assign rad_d[k]  = {rad_in[SUM_W-3:0], 2'b00};
  end

  // round root to nearest
  assign rr_d = RND_W'(root_q[ROOT_W-1])
              + RND_W'(rem_q[ROOT_W-1] > REM_W'(root_q[ROOT_W-1]));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nv[i] = NW'({ar_q[i], {FRAC_BITS{1'b0}}}) + NW'(rr_q >> 1);
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [RND_W-1:0] p_in, r_in;
      logic [QW-1:0]    l_in, q_in;
      logic [RND_W:0]   p2;
      logic             ge;

      if (j == 0) begin : g_first
        assign p_in = pp_q[i];
        assign l_in = pl_q[i];
        assign q_in = '0;
        assign r_in = rp_q;
      end else begin : g_next
        assign p_in = dp_q[j-1][i];
        assign l_in = dl_q[j-1][i];
        assign q_in = dq_q[j-1][i];
        assign r_in = dr_q[j-1];
      end

      assign p2         = {p_in, l_in[QW-1]};
      assign ge         = p2 >= {1'b0, r_in};
      assign dp_d[j][i] = ge ? RND_W'(p2 - {1'b0, r_in}) : RND_W'(p2);
      assign dq_d[j][i] = {q_in[QW-2:0], ge};
      assign dl_d[j][i] = {l_in[QW-2:0], 1'b0};
    end
  end

  // sign and saturation
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mg[i]  = XW'(dq_q[QW-1][i]);
      lim[i] = '0;
      ngv[i] = '0;
      if (err_q[OutS-1]) begin
        qo_d[i] = '0;
      end else if (neg_q[OutS-1][i]) begin
        lim[i]  = (mg[i] > MaxNeg) ? MaxNeg : mg[i];
        ngv[i]  = '0 - lim[i];
        qo_d[i] = ngv[i][DATA_WIDTH-1:0];
      end else begin
        lim[i]  = (mg[i] > MaxPos) ? MaxPos : mg[i];
        qo_d[i] = lim[i][DATA_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= rd_valid_i;
      for (int s = 1; s < NST; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      err_q[0] <= rd_data_i[EW-1];
      neg_q[0] <= rd_data_i[5*VW +: 4];
      for (int s = 1; s < OutS; s++) begin
        err_q[s] <= err_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end

      mag0_q <= mag_in;
      p_q    <= p_d;
      a1_q   <= a1_d;
      a2_q   <= a1_q;
      a3_q   <= a2_q;
      a4_q   <= a3_q;
      for (int i = 0; i < 4; i++) begin
        sq2_q[i] <= SQ_W'(a1_q[i]) * SQ_W'(a1_q[i]);
      end
      ps3_q[0] <= (SQ_W+1)'(sq2_q[0]) + (SQ_W+1)'(sq2_q[1]);
      ps3_q[1] <= (SQ_W+1)'(sq2_q[2]) + (SQ_W+1)'(sq2_q[3]);
      s4_q     <= SUM_W'(ps3_q[0]) + SUM_W'(ps3_q[1]);

      as_q[0] <= a4_q;
      for (int k = 0; k < ROOT_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
      for (int k = 1; k < ROOT_W; k++) begin
        as_q[k] <= as_q[k-1];
      end

      rr_q <= rr_d;
      ar_q <= as_q[ROOT_W-1];
      rp_q <= rr_q;
      for (int i = 0; i < 4; i++) begin
        pp_q[i] <= RND_W'(nv[i] >> QW);
        pl_q[i] <= nv[i][QW-1:0];
      end

      dr_q[0] <= rp_q;
      for (int j = 1; j < QW; j++) begin
        dr_q[j] <= dr_q[j-1];
      end
      for (int j = 0; j < QW; j++) begin
        for (int i = 0; i < 4; i++) begin
          dp_q[j][i] <= dp_d[j][i];
          dl_q[j][i] <= dl_d[j][i];
          dq_q[j][i] <= dq_d[j][i];
        end
      end

      qo_q  <= qo_d;
      bad_q <= err_q[OutS-1];
    end
  end

  assign out_o.valid     = vld_q[OutS];
  assign out_o.q_x       = qo_q[0];
  assign out_o.q_y       = qo_q[1];
  assign out_o.q_z       = qo_q[2];
  assign out_o.q_w       = qo_q[3];
  assign out_o.bad_input = bad_q;

endmodule

[hdl/rotation_matrix_to_quaternion_core.sv]
// Rotation matrix to unit quaternion top level (Shepperd's method, fixed point).
// Takes one 3x3 matrix per clock and returns one quaternion per clock once the
// pipeline is full; a stalled output holds the whole back end, while the front
// end keeps filling a two-entry queue. The back end holds a 31-stage square
// root and FRAC_BITS+1 divider stages, each of which resolves one bit. A zero
// or negative root argument gives bad_input with all components zero.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);
  import rmq_pkg::*;

  localparam int EW = 5 * vec_w(DATA_WIDTH, FRAC_BITS) + 5;

  logic          wr_valid, wr_ready, rd_valid, rd_ready;
  logic [EW-1:0] wr_data, rd_data;

  rmq_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_i      (in_i),
    .wr_valid_o(wr_valid),
    .wr_ready_i(wr_ready),
    .wr_data_o (wr_data)
  );

  rmq_fifo #(
    .Width(EW),
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(wr_valid),
    .wr_ready_o(wr_ready),
    .wr_data_i (wr_data),
    .rd_valid_o(rd_valid),
    .rd_ready_i(rd_ready),
    .rd_data_o (rd_data)
  );

  rmq_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_valid_i(rd_valid),
    .rd_ready_o(rd_ready),
    .rd_data_i (rd_data),
    .out_o     (out_o)
  );

endmodule

[hdl/rmq_checker.sv]
// port-level checks on the rotation matrix to quaternion core, bound to the top
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_core_assert.svh"

module rmq_checker #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] q_x_i,
  input logic [DATA_WIDTH-1:0] q_y_i,
  input logic [DATA_WIDTH-1:0] q_z_i,
  input logic [DATA_WIDTH-1:0] q_w_i,
  input logic                  bad_input_i
);

  logic all_zero;

  assign all_zero = (q_x_i == '0) && (q_y_i == '0) && (q_z_i == '0) && (q_w_i == '0);

  `RMQ_ASSERT_NORST(a_quiet_in_reset, !rst_ni |=> !out_valid_i, "output valid during reset")

  `RMQ_ASSERT(a_hold_on_stall, out_valid_i && !out_ready_i |=> out_valid_i, "stalled transaction dropped")

  `RMQ_ASSERT(a_bad_is_zero, out_valid_i && bad_input_i |-> all_zero, "error transaction nonzero")

  `RMQ_ASSERT(a_good_is_nonzero, out_valid_i && !bad_input_i |-> !all_zero, "good transaction zero")

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_rmq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .q_x_i      (out_o.q_x),
  .q_y_i      (out_o.q_y),
  .q_z_i      (out_o.q_z),
  .q_w_i      (out_o.q_w),
  .bad_input_i(out_o.bad_input)
);
